>>> rtl/core/s6dec_pkg.sv
// Shared types and constants for the sparse6 edge stream decoder.
// No dependencies; imported by the front, queue, back and top level.
`default_nettype none

package s6dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 36;                 // width of vertex and order fields
    localparam int K_W     = $clog2(IDX_W + 1);  // index bit count, 0..IDX_W
    localparam int SEXT_W  = 6;                  // bits carried by one text byte
    localparam int TDATA_W = ((2 * IDX_W + 2 + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] COLON_CHAR = 8'h3A;
    localparam logic [BYTE_W-1:0] SEXT_LO    = 8'd63;
    localparam logic [BYTE_W-1:0] SEXT_HI    = 8'd126;
    localparam logic [BYTE_W-1:0] LONG_MARK  = 8'd126;

    localparam logic [2:0] LEN4_REST = 3'd2;     // sextets after the first of the 4-byte form
    localparam logic [2:0] LEN8_REST = 3'd6;     // sextets of the 8-byte form

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        KIND_ORDER  = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_SHORT      = 2'd2,
        ST_BAD_BYTE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ORDER = 2'd1,
        OP_DATA  = 2'd2
    } op_t;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        op_t              op;
        logic             eot;
        status_t          status;
        logic [IDX_W-1:0] value;   // order for OP_ORDER, sextet in the low bits for OP_DATA
        logic [K_W-1:0]   k;
    } cmd_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        status_t          status;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/s6dec_front.sv
// Front end: accepts text bytes, parses header and order field, classifies bytes.
// Depends on s6dec_pkg; feeds s6dec_queue.
`default_nettype none

module s6dec_front import s6dec_pkg::*; #(
    parameter int ORDER_BITS = 36
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    typedef enum logic [5:0] {
        PH_COLON      = 6'b000001,
        PH_ORD_FIRST  = 6'b000010,
        PH_ORD_SECOND = 6'b000100,
        PH_ORD_REST   = 6'b001000,
        PH_DATA       = 6'b010000,
        PH_DRAIN      = 6'b100000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  acc_reg, acc_next;
    logic [2:0]        left_reg, left_next;
    status_t           err_reg, err_next;

    logic              accept;
    logic              byte_ok;
    logic [SEXT_W-1:0] sext;
    logic              fail;
    status_t           fail_code;
    logic              fin;
    logic [IDX_W-1:0]  fin_val;
    logic [IDX_W-1:0]  top_val;
    logic [K_W-1:0]    k_val;
    op_t               op;
    status_t           code;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign byte_ok  = s_tdata inside {[SEXT_LO:SEXT_HI]};
    assign sext     = SEXT_W'(s_tdata - SEXT_LO);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        fail       = 1'b0;
        fail_code  = ST_BAD_BYTE;
        fin        = 1'b0;
        fin_val    = acc_reg;
        op         = OP_NONE;
        code       = ST_OK;
        if (accept) begin
            case (phase_reg)
                PH_COLON: begin
                    if (s_tdata == COLON_CHAR) begin
                        phase_next = PH_ORD_FIRST;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_HEADER;
                    end
                end
                PH_ORD_FIRST: begin
                    if (!byte_ok) begin
                        fail = 1'b1;
                    end else if (s_tdata == LONG_MARK) begin
                        phase_next = PH_ORD_SECOND;
                    end else begin
                        fin     = 1'b1;
                        fin_val = IDX_W'(sext);
                    end
                end
                PH_ORD_SECOND: begin
                    if (s_tdata == LONG_MARK) begin
                        acc_next   = '0;
                        left_next  = LEN8_REST;
                        phase_next = PH_ORD_REST;
                    end else if (!byte_ok) begin
                        fail = 1'b1;
                    end else begin
                        acc_next   = IDX_W'(sext);
                        left_next  = LEN4_REST;
                        phase_next = PH_ORD_REST;
                    end
                end
                PH_ORD_REST: begin
                    if (!byte_ok) begin
                        fail = 1'b1;
                    end else begin
                        acc_next  = {acc_reg[IDX_W-SEXT_W-1:0], sext};
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1) begin
                            fin     = 1'b1;
                            fin_val = acc_next;
                        end
                    end
                end
                PH_DATA: begin
                    if (!byte_ok) begin
                        fail = 1'b1;
                    end else begin
                        op = OP_DATA;
                    end
                end
                default: begin
                    // draining: ignore everything up to the end of the text
                end
            endcase

            // an order too wide for the index datapath counts as a bad byte
            if (fin) begin
                if ((fin_val >> ORDER_BITS) != '0) begin
                    fail = 1'b1;
                end else begin
                    op         = OP_ORDER;
                    phase_next = PH_DATA;
                end
            end

            if (fail) begin
                if (err_reg == ST_OK) begin
                    err_next = fail_code;
                end
                phase_next = PH_DRAIN;
            end

            code = err_next;
            if (code == ST_OK && (phase_next == PH_COLON || phase_next == PH_ORD_FIRST ||
                                  phase_next == PH_ORD_SECOND || phase_next == PH_ORD_REST)) begin
                code = ST_SHORT;
            end

            if (s_tlast) begin
                phase_next = PH_COLON;
                acc_next   = '0;
                left_next  = '0;
                err_next   = ST_OK;
            end
        end
    end

    // k = bit length of order-1
    always_comb begin
        top_val = (fin_val == '0) ? '0 : fin_val - IDX_W'(1);
        k_val   = '0;
        for (int i = 0; i < IDX_W; i++) begin
            if (top_val[i]) begin
                k_val = K_W'(i + 1);
            end
        end
    end

    always_comb begin
        q_cmd.op     = op;
        q_cmd.eot    = s_tlast;
        q_cmd.status = code;
        q_cmd.value  = fin ? fin_val : IDX_W'(sext);
        q_cmd.k      = k_val;
    end

    assign q_push = accept && (op != OP_NONE || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COLON;
            acc_reg   <= '0;
            left_reg  <= '0;
            err_reg   <= ST_OK;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    ap_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK && !(accept && s_tlast)) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed before end of text");

    ap_err_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK) |-> (phase_reg == PH_DRAIN))
        else $error("error latched but parser not draining");

endmodule

`default_nettype wire

>>> rtl/core/s6dec_queue.sv
// Short command queue between the front and back ends.
// Depends on s6dec_pkg for cmd_t and the queue depth.
`default_nettype none

module s6dec_queue import s6dec_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full       = count_reg == (Q_AW + 1)'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (Q_AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (Q_AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/s6dec_back.sv
// Back end: walks the data bits one per cycle while the output is not stalled,
// tracks the vertex, builds results. Uses s6dec_pkg; reads s6dec_queue commands.
`default_nettype none

module s6dec_back import s6dec_pkg::*; #(
    parameter int ORDER_BITS = 36
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire cmd_t q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res,
    output logic      m_last
);

    localparam int OW = ORDER_BITS;
    localparam int GW = ORDER_BITS + 1;
    localparam int KW = $clog2(ORDER_BITS + 1);
    localparam logic [2:0] BIT_TOP = 3'(SEXT_W - 1);

    typedef enum logic [1:0] {
        BK_MAIN   = 2'b01,
        BK_STATUS = 2'b10
    } bk_t;

    bk_t             bk_reg, bk_next;
    logic [2:0]      bit_idx_reg, bit_idx_next;
    logic            stopped_reg, stopped_next;
    logic [OW-1:0]   order_reg, order_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [OW-1:0]   v_reg, v_next;
    logic [GW-1:0]   shift_reg, shift_next;
    logic [KW-1:0]   fill_reg, fill_next;

    logic            p_valid_reg, p_valid_next;
    logic            p_final_reg, p_final_next;
    res_t            p_res_reg, p_res_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_last_reg, m_last_next;
    res_t            m_res_reg, m_res_next;

    logic            can_out;
    logic            step;
    logic            in_status;
    logic [SEXT_W-1:0] sext;
    logic            bit_in;
    logic [GW-1:0]   shift_new;
    logic            grp_full;
    logic            b_bit;
    logic [OW-1:0]   x_val;
    logic [OW-1:0]   v_inc;
    logic            stop_now;
    logic            new_valid;
    res_t            new_res;
    logic            byte_end;
    logic            main_done;
    logic            push_out;

    assign can_out   = !m_valid_reg || m_ready;
    assign step      = q_valid && (can_out || !p_valid_reg);
    assign in_status = (bk_reg == BK_STATUS) || (q_head.op == OP_NONE);

    // group datapath for the current bit
    assign sext      = q_head.value[SEXT_W-1:0];
    assign bit_in    = sext[bit_idx_reg];
    assign shift_new = {shift_reg[GW-2:0], bit_in};
    assign grp_full  = fill_reg == k_reg;
    assign b_bit     = shift_new[k_reg];
    assign v_inc     = v_reg + OW'(b_bit);
    assign stop_now  = (x_val >= order_reg) || (v_inc >= order_reg);

    always_comb begin
        for (int i = 0; i < OW; i++) begin
            x_val[i] = shift_new[i] && (KW'(i) < k_reg);
        end
    end

    always_comb begin
        bk_next      = bk_reg;
        bit_idx_next = bit_idx_reg;
        stopped_next = stopped_reg;
        order_next   = order_reg;
        k_next       = k_reg;
        v_next       = v_reg;
        shift_next   = shift_reg;
        fill_next    = fill_reg;
        new_valid    = 1'b0;
        new_res      = '{kind: KIND_EDGE, lo: '0, hi: '0, status: ST_OK};
        byte_end     = 1'b0;
        main_done    = 1'b0;
        q_pop        = 1'b0;
        if (step) begin
            if (in_status) begin
                new_valid      = 1'b1;
                new_res.kind   = KIND_STATUS;
                new_res.status = q_head.status;
                byte_end       = 1'b1;
                q_pop          = 1'b1;
                bk_next        = BK_MAIN;
            end else begin
                case (q_head.op)
                    OP_ORDER: begin
                        new_valid    = 1'b1;
                        new_res.kind = KIND_ORDER;
                        new_res.hi   = IDX_W'(q_head.value[OW-1:0]);
                        order_next   = q_head.value[OW-1:0];
                        k_next       = q_head.k[KW-1:0];
                        v_next       = '0;
                        shift_next   = '0;
                        fill_next    = '0;
                        stopped_next = 1'b0;
                        main_done    = 1'b1;
                    end
                    OP_DATA: begin
                        if (!stopped_reg) begin
                            if (grp_full) begin
                                shift_next = '0;
                                fill_next  = '0;
                                v_next     = v_inc;
                                if (stop_now) begin
                                    stopped_next = 1'b1;
                                end else if (x_val > v_inc) begin
                                    v_next = x_val;
                                end else begin
                                    new_valid    = 1'b1;
                                    new_res.kind = KIND_EDGE;
                                    new_res.lo   = IDX_W'(x_val);
                                    new_res.hi   = IDX_W'(v_inc);
                                end
                            end else begin
                                shift_next = shift_new;
                                fill_next  = fill_reg + KW'(1);
                            end
                        end
                        if (bit_idx_reg == '0) begin
                            main_done    = 1'b1;
                            bit_idx_next = BIT_TOP;
                        end else begin
                            bit_idx_next = bit_idx_reg - 3'd1;
                        end
                    end
                    default: begin
                        main_done = 1'b1;
                    end
                endcase
                if (main_done) begin
                    if (q_head.eot) begin
                        bk_next = BK_STATUS;
                    end else begin
                        q_pop    = 1'b1;
                        byte_end = 1'b1;
                    end
                end
            end
        end
    end

    // hold one result back until we know whether it closes its byte
    always_comb begin
        push_out     = (new_valid && p_valid_reg) ||
                       (!new_valid && p_valid_reg && p_final_reg && can_out);
        p_valid_next = p_valid_reg;
        p_final_next = p_final_reg;
        p_res_next   = p_res_reg;
        if (new_valid) begin
            p_valid_next = 1'b1;
            p_final_next = byte_end;
            p_res_next   = new_res;
        end else if (push_out) begin
            p_valid_next = 1'b0;
        end else if (byte_end && p_valid_reg) begin
            p_final_next = 1'b1;
        end

        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        m_res_next   = m_res_reg;
        if (push_out) begin
            m_valid_next = 1'b1;
            m_last_next  = p_final_reg;
            m_res_next   = p_res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_last  = m_last_reg;
    assign m_res   = m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bk_reg      <= BK_MAIN;
            bit_idx_reg <= BIT_TOP;
            stopped_reg <= 1'b0;
            fill_reg    <= '0;
            p_valid_reg <= 1'b0;
            p_final_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            bk_reg      <= bk_next;
            bit_idx_reg <= bit_idx_next;
            stopped_reg <= stopped_next;
            fill_reg    <= fill_next;
            p_valid_reg <= p_valid_next;
            p_final_reg <= p_final_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        order_reg  <= order_next;
        k_reg      <= k_next;
        v_reg      <= v_next;
        shift_reg  <= shift_next;
        p_res_reg  <= p_res_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    ap_none_eot: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_head.op == OP_NONE) |-> q_head.eot)
        else $error("queued byte with no work and no end of text");

    ap_vertex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_head.op == OP_DATA && !stopped_reg && order_reg != '0)
        |-> (v_reg < order_reg))
        else $error("current vertex reached the order while decoding");

    ap_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.kind == KIND_STATUS) |-> m_last_reg)
        else $error("status result not marked as last of its byte");

endmodule

`default_nettype wire

>>> rtl/core/sparse6_edge_stream_decoder_unit.sv
// Sparse6 edge stream decoder: top level, ties front, queue and back together.
// Depends on s6dec_pkg, s6dec_front, s6dec_queue and s6dec_back.
//
// Usage
//   Slave channel: one text byte per beat on s_tdata, starting with the colon;
//   s_tlast marks the final byte of the graph. Master channel: one result per
//   beat, m_tuser gives the kind (order, edge, status), m_tlast marks the last
//   result caused by one input byte.
//   Path: a result reaches the master side through the queue entry, the back
//   end's pending register and the output register; each command already queued
//   ahead adds its own back end time. The last result of a byte waits until
//   the byte's bits are all walked.
//   Throughput: the back end walks one data bit per cycle while its output is
//   not stalled; an order-completing byte takes a step of its own, and end of
//   text a step for its status. Header and intermediate order bytes cost no back
//   end time. The front keeps taking bytes while the four-entry queue has room.
//   Reset: aresetn low for one edge returns the parser to expecting a colon and
//   empties the queue and output stage.
//   Stall: with m_tready low the back end holds once one result waits behind
//   the output register, the queue fills, and s_tready falls; nothing is lost.
`default_nettype none

module sparse6_edge_stream_decoder_unit import s6dec_pkg::*; #(
    parameter int ORDER_BITS = 36
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // slave side
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
    input  wire logic               s_tlast,
    // master side
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [35:0] low_index, [71:36] high_index,
                                               // [73:72] status, [79:74] zero
    output logic [1:0]              m_tuser,   // [1:0] kind
    output logic                    m_tlast
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;
    res_t res;

    // classify bytes and track the header and order field
    s6dec_front #(
        .ORDER_BITS (ORDER_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // decouple byte intake from the bit walker
    s6dec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // walk groups, emit order, edges and status
    s6dec_back #(
        .ORDER_BITS (ORDER_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res),
        .m_last  (m_tlast)
    );

    // pack the result beat, low field first
    assign m_tdata = {{(TDATA_W - 2 * IDX_W - 2){1'b0}}, res.status, res.hi, res.lo};
    assign m_tuser = res.kind;

endmodule

`default_nettype wire
